@@ design/u8cv_pkg.sv @@
// shared types, constants and the whitespace test for the utf-8 content validator
`default_nettype none

package u8cv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LIMIT_W = 16;

    localparam logic [LIMIT_W-1:0] MAX_BYTES_RESET = 16'd4096;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 17'h1FFFF;

    // lead byte ranges
    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
    localparam logic [BYTE_W-1:0] ASCII_HI = 8'h7F;

    // code point limits
    localparam logic [POINT_W-1:0] MIN_3BYTE   = 21'h000800;
    localparam logic [POINT_W-1:0] MIN_4BYTE   = 21'h010000;
    localparam logic [POINT_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [POINT_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [POINT_W-1:0] MAX_SCALAR  = 21'h10FFFF;

    // sequence lengths
    localparam logic [2:0] SEQ_W2 = 3'd2;
    localparam logic [2:0] SEQ_W3 = 3'd3;
    localparam logic [2:0] SEQ_W4 = 3'd4;

    typedef enum logic [2:0] {
        VERDICT_PENDING  = 3'd0,
        VERDICT_ACCEPTED = 3'd1,
        VERDICT_BAD_ENC  = 3'd2,
        VERDICT_TOO_LONG = 3'd3,
        VERDICT_BLANK    = 3'd4
    } t_verdict;

    // per-entry decode state
    typedef struct packed {
        logic [1:0]         bytes_left;
        logic [2:0]         seq_width;
        logic [POINT_W-1:0] partial_point;
        logic [COUNT_W-1:0] byte_count;
        logic               bad_seen;
        logic               nonblank_seen;
    } t_state;

    // one result item
    typedef struct packed {
        logic               point_ready;
        logic [POINT_W-1:0] code_point;
        logic               is_space;
        logic               done_res;
        t_verdict           verdict;
    } t_result;

    // unicode whitespace test
    function automatic logic is_space_point(input logic [POINT_W-1:0] p);
        is_space_point = (p == 21'h000020) ||
                         (p >= 21'h000009 && p <= 21'h00000D) ||
                         (p == 21'h000085) || (p == 21'h0000A0) ||
                         (p == 21'h001680) ||
                         (p >= 21'h002000 && p <= 21'h00200A) ||
                         (p == 21'h002028) || (p == 21'h002029) ||
                         (p == 21'h00202F) || (p == 21'h00205F) ||
                         (p == 21'h003000);
    endfunction

endpackage

`default_nettype wire

@@ design/u8cv_in_if.sv @@
// input byte channel of the utf-8 content validator
`default_nettype none

interface u8cv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input has_byte, input last,
                    output ready);
endinterface

`default_nettype wire

@@ design/u8cv_out_if.sv @@
// result channel of the utf-8 content validator
`default_nettype none

interface u8cv_out_if;
    logic        valid;
    logic        ready;
    logic        point_ready;
    logic [20:0] code_point;
    logic        is_space;
    logic        done_res;
    logic [2:0]  verdict;

    modport source (output valid, output point_ready, output code_point,
                    output is_space, output done_res, output verdict, input ready);
    modport sink   (input valid, input point_ready, input code_point,
                    input is_space, input done_res, input verdict, output ready);
endinterface

`default_nettype wire

@@ design/u8cv_cfg_if.sv @@
// configuration write channel of the utf-8 content validator
`default_nettype none

interface u8cv_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/utf8_content_validator_core.sv @@
// top level of the utf-8 content validator: entry state, limit register, result register
//
//   channel   dir   payload                                          accepted when
//   i_in      in    data_byte[7:0], has_byte, last                   valid & ready
//   o_out     out   point_ready, code_point[20:0], is_space,         valid & ready
//                   done_res, verdict[2:0]
//   i_cfg     in    data[15:0] -> max_bytes                          valid & ready
//
// one item per cycle unless o_out stalls; one result per item, shown the next cycle.
// the decode step sits between the input port and the result register, one pass per byte.
// i_in.ready is high while the result register is empty or being drained this cycle.
// synchronous active-low reset clears entry state, sets max_bytes to 4096, empties the output.
// i_cfg is always ready; writes are meant to land only while the block is idle.
`default_nettype none

module utf8_content_validator_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8cv_in_if.sink     i_in,
    u8cv_out_if.source  o_out,
    u8cv_cfg_if.sink    i_cfg
);

    u8cv_pkg::t_state  r_state;
    u8cv_pkg::t_state  n_state;
    u8cv_pkg::t_result r_result;
    u8cv_pkg::t_result n_result;
    logic              r_out_valid;
    logic [15:0]       r_max_bytes;
    logic              in_fire;

    // handshakes
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // per-byte decode
    u8cv_step u_step (
        .i_state     (r_state),
        .i_data_byte (i_in.data_byte),
        .i_has_byte  (i_in.has_byte),
        .i_last      (i_in.last),
        .i_max_bytes (r_max_bytes),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
            r_max_bytes <= u8cv_pkg::MAX_BYTES_RESET;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_bytes <= i_cfg.data;
            end
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    // output drive
    assign o_out.valid       = r_out_valid;
    assign o_out.point_ready = r_result.point_ready;
    assign o_out.code_point  = r_result.code_point;
    assign o_out.is_space    = r_result.is_space;
    assign o_out.done_res    = r_result.done_res;
    assign o_out.verdict     = r_result.verdict;

    // entry state is cleared after an end item
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.last |=> r_state == '0)
        else $error("entry state not cleared after end item");

    // every accepted item yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted item produced no result");

    // an open sequence means decoding is live with a known width
    a_open_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_left != 2'd0 |-> !r_state.bad_seen && r_state.seq_width != 3'd0)
        else $error("open sequence with inconsistent decode state");

    // reported points are unicode scalar values
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.point_ready |->
            r_result.code_point <= u8cv_pkg::MAX_SCALAR &&
            (r_result.code_point < u8cv_pkg::SURR_LO ||
             r_result.code_point > u8cv_pkg::SURR_HI))
        else $error("reported code point is not a scalar value");

    // a verdict only comes with the end item
    a_verdict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_result.done_res |-> r_result.verdict == u8cv_pkg::VERDICT_PENDING)
        else $error("verdict without end item");

endmodule

`default_nettype wire

@@ design/u8cv_step.sv @@
// next-state and result logic for one byte item of the validator
`default_nettype none

module u8cv_step (
    input  wire u8cv_pkg::t_state  i_state,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_has_byte,
    input  wire logic              i_last,
    input  wire logic [15:0]       i_max_bytes,
    output u8cv_pkg::t_state       o_state,
    output u8cv_pkg::t_result      o_result
);

    u8cv_pkg::t_state  n_state;
    u8cv_pkg::t_result n_result;
    logic [20:0]       n_point;

    // decode one byte, then form the verdict on the end item
    always_comb begin
        n_state  = i_state;
        n_result = '0;
        n_point  = {i_state.partial_point[14:0], i_data_byte[5:0]};

        if (i_has_byte) begin
            if (i_state.byte_count != u8cv_pkg::COUNT_MAX) begin
                n_state.byte_count = i_state.byte_count + 17'd1;
            end
            if (!i_state.bad_seen) begin
                if (i_state.bytes_left == 2'd0) begin
                    // lead byte classification
                    priority if (i_data_byte == 8'h00) begin
                        n_state.bad_seen = 1'b1;
                    end else if (i_data_byte <= u8cv_pkg::ASCII_HI) begin
                        n_result.point_ready = 1'b1;
                        n_result.code_point  = {13'd0, i_data_byte};
                    end else if (i_data_byte >= u8cv_pkg::LEAD2_LO &&
                                 i_data_byte <= u8cv_pkg::LEAD2_HI) begin
                        n_state.seq_width     = u8cv_pkg::SEQ_W2;
                        n_state.bytes_left    = 2'd1;
                        n_state.partial_point = {16'd0, i_data_byte[4:0]};
                    end else if (i_data_byte >= u8cv_pkg::LEAD3_LO &&
                                 i_data_byte <= u8cv_pkg::LEAD3_HI) begin
                        n_state.seq_width     = u8cv_pkg::SEQ_W3;
                        n_state.bytes_left    = 2'd2;
                        n_state.partial_point = {17'd0, i_data_byte[3:0]};
                    end else if (i_data_byte >= u8cv_pkg::LEAD4_LO &&
                                 i_data_byte <= u8cv_pkg::LEAD4_HI) begin
                        n_state.seq_width     = u8cv_pkg::SEQ_W4;
                        n_state.bytes_left    = 2'd3;
                        n_state.partial_point = {18'd0, i_data_byte[2:0]};
                    end else begin
                        n_state.bad_seen = 1'b1;
                    end
                end else if (i_data_byte[7:6] != 2'b10) begin
                    // continuation byte expected but not found
                    n_state.bad_seen   = 1'b1;
                    n_state.bytes_left = 2'd0;
                end else begin
                    n_state.partial_point = n_point;
                    n_state.bytes_left    = i_state.bytes_left - 2'd1;
                    if (i_state.bytes_left == 2'd1) begin
                        // sequence complete: reject overlong, surrogate, out of range
                        if ((i_state.seq_width == u8cv_pkg::SEQ_W3 &&
                             n_point < u8cv_pkg::MIN_3BYTE) ||
                            (i_state.seq_width == u8cv_pkg::SEQ_W4 &&
                             n_point < u8cv_pkg::MIN_4BYTE) ||
                            (n_point >= u8cv_pkg::SURR_LO &&
                             n_point <= u8cv_pkg::SURR_HI) ||
                            (n_point > u8cv_pkg::MAX_SCALAR)) begin
                            n_state.bad_seen = 1'b1;
                        end else begin
                            n_result.point_ready = 1'b1;
                            n_result.code_point  = n_point;
                        end
                        n_state.seq_width     = 3'd0;
                        n_state.partial_point = '0;
                    end
                end
                // whitespace flag for a completed point
                if (n_result.point_ready) begin
                    n_result.is_space = u8cv_pkg::is_space_point(n_result.code_point);
                    if (!n_result.is_space) begin
                        n_state.nonblank_seen = 1'b1;
                    end
                end
            end
        end

        // verdict on the end item, then clear the entry
        if (i_last) begin
            n_result.done_res = 1'b1;
            priority if (n_state.bad_seen || n_state.bytes_left != 2'd0) begin
                n_result.verdict = u8cv_pkg::VERDICT_BAD_ENC;
            end else if (n_state.byte_count > {1'b0, i_max_bytes}) begin
                n_result.verdict = u8cv_pkg::VERDICT_TOO_LONG;
            end else if (!n_state.nonblank_seen) begin
                n_result.verdict = u8cv_pkg::VERDICT_BLANK;
            end else begin
                n_result.verdict = u8cv_pkg::VERDICT_ACCEPTED;
            end
            n_state = '0;
        end
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule

`default_nettype wire

@@ dv/utf8_content_validator_core_tb.sv @@
// self-checking testbench for the utf-8 content validator: directed rows, then random entries

module utf8_content_validator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 40;
    localparam logic [u8cv_pkg::LIMIT_W-1:0] LIMIT_AT_RESET = 16'd4096;

    localparam u8cv_pkg::t_result NO_RESULT = '0;

    // directed stimulus row; want is only used when pin is set
    typedef struct packed {
        logic [7:0]        data_byte;
        logic              has_byte;
        logic              last;
        logic              pin;
        u8cv_pkg::t_result want;
    } t_row;

    localparam t_row DIRECTED [0:24] = '{
        // idle item
        '{8'h00, 1'b0, 1'b0, 1'b1, NO_RESULT},
        // highest ascii, byte on the end item
        '{8'h7F, 1'b1, 1'b1, 1'b1,
          {1'b1, 21'h00007F, 1'b0, 1'b1, u8cv_pkg::VERDICT_ACCEPTED}},
        // nul lead byte
        '{8'h00, 1'b1, 1'b1, 1'b1,
          {1'b0, 21'h000000, 1'b0, 1'b1, u8cv_pkg::VERDICT_BAD_ENC}},
        // bad lead byte at the top of the range
        '{8'hFF, 1'b1, 1'b1, 1'b1,
          {1'b0, 21'h000000, 1'b0, 1'b1, u8cv_pkg::VERDICT_BAD_ENC}},
        // overlong 3-byte form
        '{8'hE0, 1'b1, 1'b0, 1'b1, NO_RESULT},
        '{8'h80, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, 1'b1, 1'b1,
          {1'b0, 21'h000000, 1'b0, 1'b1, u8cv_pkg::VERDICT_BAD_ENC}},
        // surrogate
        '{8'hED, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'hA0, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, 1'b1, 1'b1,
          {1'b0, 21'h000000, 1'b0, 1'b1, u8cv_pkg::VERDICT_BAD_ENC}},
        // largest scalar value
        '{8'hF4, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h8F, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'hBF, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'hBF, 1'b1, 1'b1, 1'b1,
          {1'b1, 21'h10FFFF, 1'b0, 1'b1, u8cv_pkg::VERDICT_ACCEPTED}},
        // one past the largest scalar value
        '{8'hF4, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h90, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, 1'b1, 1'b1,
          {1'b0, 21'h000000, 1'b0, 1'b1, u8cv_pkg::VERDICT_BAD_ENC}},
        // ideographic space only: blank entry
        '{8'hE3, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b1, 1'b1, 1'b1,
          {1'b1, 21'h003000, 1'b1, 1'b1, u8cv_pkg::VERDICT_BLANK}},
        // lead byte followed by a non-continuation byte
        '{8'hE2, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h41, 1'b1, 1'b1, 1'b1,
          {1'b0, 21'h000000, 1'b0, 1'b1, u8cv_pkg::VERDICT_BAD_ENC}},
        // sequence cut off by an end-only item
        '{8'hC3, 1'b1, 1'b0, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, 1'b1, 1'b1,
          {1'b0, 21'h000000, 1'b0, 1'b1, u8cv_pkg::VERDICT_BAD_ENC}}
    };

    localparam logic [u8cv_pkg::POINT_W-1:0] SPACE_POINTS [0:24] = '{
        21'h09, 21'h0A, 21'h0B, 21'h0C, 21'h0D, 21'h20, 21'h85, 21'hA0, 21'h1680,
        21'h2000, 21'h2001, 21'h2002, 21'h2003, 21'h2004, 21'h2005, 21'h2006,
        21'h2007, 21'h2008, 21'h2009, 21'h200A, 21'h2028, 21'h2029, 21'h202F,
        21'h205F, 21'h3000
    };

    localparam logic [u8cv_pkg::POINT_W-1:0] BOUNDARY_POINTS [0:9] = '{
        21'h01, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000, 21'hFFFF,
        21'h10000, 21'h10FFFF
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8cv_in_if  byte_ch ();
    u8cv_out_if point_ch ();
    u8cv_cfg_if limit_ch ();

    utf8_content_validator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (point_ch),
        .i_cfg   (limit_ch)
    );

    // decoder image kept in step with accepted items
    logic [1:0]                       dec_left;
    logic [2:0]                       dec_width;
    logic [u8cv_pkg::POINT_W-1:0]     dec_acc;
    logic [u8cv_pkg::COUNT_W-1:0]     dec_count;
    logic                             dec_bad;
    logic                             dec_printable;
    logic [u8cv_pkg::LIMIT_W-1:0]     byte_limit;

    u8cv_pkg::t_result pending_results [$];
    logic [7:0]        entry_q [$];

    bit src_gaps;
    bit sink_stalls;
    int fed_items;
    int mismatch_count;
    int quiet_cycles = 0;
    int verdict_tally [0:4];

    always #1 i_clk = ~i_clk;

    // unicode whitespace
    function automatic logic white_point(input logic [u8cv_pkg::POINT_W-1:0] p);
        return (p >= 21'h09 && p <= 21'h0D) || p == 21'h20 || p == 21'h85 ||
               p == 21'hA0 || p == 21'h1680 || (p >= 21'h2000 && p <= 21'h200A) ||
               p == 21'h2028 || p == 21'h2029 || p == 21'h202F || p == 21'h205F ||
               p == 21'h3000;
    endfunction

    function automatic void clear_decoder();
        dec_left      = '0;
        dec_width     = '0;
        dec_acc       = '0;
        dec_count     = '0;
        dec_bad       = 1'b0;
        dec_printable = 1'b0;
    endfunction

    // advance the decoder image by one item and form the expected result
    function automatic u8cv_pkg::t_result decode_step(input logic [7:0] b, input logic hb,
                                                      input logic lst);
        u8cv_pkg::t_result r;
        r = '0;
        if (hb) begin
            if (dec_count != u8cv_pkg::COUNT_MAX)
                dec_count = dec_count + 1'b1;
            if (!dec_bad) begin
                if (dec_left == 2'd0) begin
                    if (b == 8'h00) begin
                        dec_bad = 1'b1;
                    end else if (b <= u8cv_pkg::ASCII_HI) begin
                        r.point_ready = 1'b1;
                        r.code_point  = {13'd0, b};
                    end else if (b >= u8cv_pkg::LEAD2_LO && b <= u8cv_pkg::LEAD2_HI) begin
                        dec_width = u8cv_pkg::SEQ_W2;
                        dec_left  = 2'd1;
                        dec_acc   = {16'd0, b[4:0]};
                    end else if (b >= u8cv_pkg::LEAD3_LO && b <= u8cv_pkg::LEAD3_HI) begin
                        dec_width = u8cv_pkg::SEQ_W3;
                        dec_left  = 2'd2;
                        dec_acc   = {17'd0, b[3:0]};
                    end else if (b >= u8cv_pkg::LEAD4_LO && b <= u8cv_pkg::LEAD4_HI) begin
                        dec_width = u8cv_pkg::SEQ_W4;
                        dec_left  = 2'd3;
                        dec_acc   = {18'd0, b[2:0]};
                    end else begin
                        dec_bad = 1'b1;
                    end
                end else if (b[7:6] != 2'b10) begin
                    dec_bad  = 1'b1;
                    dec_left = 2'd0;
                end else begin
                    dec_acc  = {dec_acc[14:0], b[5:0]};
                    dec_left = dec_left - 2'd1;
                    if (dec_left == 2'd0) begin
                        if ((dec_width == u8cv_pkg::SEQ_W3 && dec_acc < u8cv_pkg::MIN_3BYTE) ||
                            (dec_width == u8cv_pkg::SEQ_W4 && dec_acc < u8cv_pkg::MIN_4BYTE) ||
                            (dec_acc >= u8cv_pkg::SURR_LO && dec_acc <= u8cv_pkg::SURR_HI) ||
                            dec_acc > u8cv_pkg::MAX_SCALAR) begin
                            dec_bad = 1'b1;
                        end else begin
                            r.point_ready = 1'b1;
                            r.code_point  = dec_acc;
                        end
                        dec_width = '0;
                        dec_acc   = '0;
                    end
                end
                if (r.point_ready) begin
                    r.is_space = white_point(r.code_point);
                    if (!r.is_space)
                        dec_printable = 1'b1;
                end
            end
        end
        if (lst) begin
            r.done_res = 1'b1;
            if (dec_bad || dec_left != 2'd0)
                r.verdict = u8cv_pkg::VERDICT_BAD_ENC;
            else if (dec_count > {1'b0, byte_limit})
                r.verdict = u8cv_pkg::VERDICT_TOO_LONG;
            else if (!dec_printable)
                r.verdict = u8cv_pkg::VERDICT_BLANK;
            else
                r.verdict = u8cv_pkg::VERDICT_ACCEPTED;
            clear_decoder();
        end
        return r;
    endfunction

    // offer one item, optionally after a gap, and record its expected result
    task automatic push_item(input logic [7:0] b, input logic hb, input logic lst,
                             input logic pin = 1'b0,
                             input u8cv_pkg::t_result pinned = '0);
        u8cv_pkg::t_result r;
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.has_byte  <= hb;
        byte_ch.last      <= lst;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        r = decode_step(b, hb, lst);
        if (pin)
            r = pinned;
        pending_results = {pending_results, r};
        if (hb || lst)
            fed_items++;
        if (lst)
            verdict_tally[int'(r.verdict)]++;
    endtask

    // hold the sender until every expected result is back
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_limit(input logic [u8cv_pkg::LIMIT_W-1:0] v);
        limit_ch.valid <= 1'b1;
        limit_ch.data  <= v;
        do @(posedge i_clk); while (limit_ch.ready !== 1'b1);
        limit_ch.valid <= 1'b0;
        byte_limit = v;
    endtask

    function automatic void append_byte(input logic [7:0] b);
        entry_q = {entry_q, b};
    endfunction

    function automatic void add_point(input logic [u8cv_pkg::POINT_W-1:0] p);
        if (p < 21'h80) begin
            append_byte(p[7:0]);
        end else if (p < 21'h800) begin
            append_byte({3'b110, p[10:6]});
            append_byte({2'b10, p[5:0]});
        end else if (p < 21'h10000) begin
            append_byte({4'b1110, p[15:12]});
            append_byte({2'b10, p[11:6]});
            append_byte({2'b10, p[5:0]});
        end else begin
            append_byte({5'b11110, p[20:18]});
            append_byte({2'b10, p[17:12]});
            append_byte({2'b10, p[11:6]});
            append_byte({2'b10, p[5:0]});
        end
    endfunction

    function automatic logic [u8cv_pkg::POINT_W-1:0] pick_point();
        logic [u8cv_pkg::POINT_W-1:0] p;
        case ($urandom_range(0, 9))
            0, 1, 2: p = 21'($urandom_range(1, 'h7F));
            3, 4:    p = SPACE_POINTS[$urandom_range(0, 24)];
            5:       p = 21'($urandom_range('h80, 'h7FF));
            6: begin
                p = 21'($urandom_range('h800, 'hF7FF));
                if (p >= u8cv_pkg::SURR_LO)
                    p = p + 21'h800;
            end
            7:       p = 21'($urandom_range('h10000, 'h10FFFF));
            default: p = BOUNDARY_POINTS[$urandom_range(0, 9)];
        endcase
        return p;
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range('h80, 'hBF));
    endfunction

    // fill entry_q with one entry: clean text, blank, broken, noise or empty
    task automatic build_entry();
        int unsigned kind;
        int unsigned n;
        int unsigned idx;
        entry_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            n = $urandom_range(1, 12);
            repeat (n) add_point(pick_point());
        end else if (kind < 65) begin
            n = $urandom_range(1, 6);
            repeat (n) add_point(SPACE_POINTS[$urandom_range(0, 24)]);
        end else if (kind < 85) begin
            n = $urandom_range(1, 8);
            repeat (n) add_point(pick_point());
            idx = $urandom_range(0, entry_q.size() - 1);
            case ($urandom_range(0, 4))
                0: entry_q[idx] = 8'($urandom_range(0, 255));
                1: entry_q.delete(entry_q.size() - 1);
                2: entry_q.insert(idx, cont_byte());
                3: entry_q.insert(idx, 8'($urandom_range('hC2, 'hF4)));
                default: begin
                    // malformed sequence followed by zero to three more points
                    case ($urandom_range(0, 5))
                        0: begin
                            append_byte(8'hE0);
                            append_byte(8'($urandom_range('h80, 'h9F)));
                            append_byte(cont_byte());
                        end
                        1: begin
                            append_byte(8'hF0);
                            append_byte(8'($urandom_range('h80, 'h8F)));
                            append_byte(cont_byte());
                            append_byte(cont_byte());
                        end
                        2: begin
                            append_byte(8'hED);
                            append_byte(8'($urandom_range('hA0, 'hBF)));
                            append_byte(cont_byte());
                        end
                        3: begin
                            append_byte(8'hF4);
                            append_byte(8'($urandom_range('h90, 'hBF)));
                            append_byte(cont_byte());
                            append_byte(cont_byte());
                        end
                        4: begin
                            if ($urandom_range(0, 1))
                                append_byte(8'($urandom_range('hC0, 'hC1)));
                            else
                                append_byte(8'($urandom_range('hF5, 'hFF)));
                        end
                        default: append_byte(8'h00);
                    endcase
                    n = $urandom_range(0, 3);
                    repeat (n) add_point(pick_point());
                end
            endcase
        end else if (kind < 93) begin
            n = $urandom_range(1, 8);
            repeat (n) append_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // send entry_q, ending on the last byte or with an end-only item
    task automatic send_entry();
        bit end_on_byte;
        end_on_byte = $urandom_range(0, 1);
        foreach (entry_q[i]) begin
            if ($urandom_range(0, 19) == 0)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_item(entry_q[i], 1'b1, end_on_byte && i == entry_q.size() - 1);
        end
        if (!end_on_byte || entry_q.size() == 0)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic run_entries(input int quota, input bit idling, input bit pauses);
        int start;
        src_gaps    = idling;
        sink_stalls = idling;
        start       = fed_items;
        while (fed_items - start < quota) begin
            build_entry();
            send_entry();
            if (pauses && $urandom_range(0, 14) == 0)
                drain_results();
        end
    endtask

    task automatic compare_field(input string name,
                                 input logic [u8cv_pkg::POINT_W-1:0] want,
                                 input logic [u8cv_pkg::POINT_W-1:0] got);
        if (want !== got) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result sink with random stall bursts
    initial begin
        point_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_stalls && $urandom_range(0, 7) == 0) begin
                point_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            point_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // compare each accepted result item with the oldest expectation
    always @(posedge i_clk) begin : result_check
        u8cv_pkg::t_result got;
        u8cv_pkg::t_result want;
        if (i_rst_n && point_ch.valid && point_ch.ready) begin
            got = {point_ch.point_ready, point_ch.code_point, point_ch.is_space,
                   point_ch.done_res, point_ch.verdict};
            if (pending_results.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("%0t: result item with nothing expected, actual %0h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("point_ready", 21'(want.point_ready), 21'(got.point_ready));
                compare_field("code_point", want.code_point, got.code_point);
                compare_field("is_space", 21'(want.is_space), 21'(got.is_space));
                compare_field("done_res", 21'(want.done_res), 21'(got.done_res));
                compare_field("verdict", 21'(want.verdict), 21'(got.verdict));
            end
        end
    end

    // watchdog on cycles where no channel moves an item
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (point_ch.valid && point_ch.ready) ||
            (limit_ch.valid && limit_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // reset, directed rows, then random phases under several byte limits
    initial begin
        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.has_byte  <= 1'b0;
        byte_ch.last      <= 1'b0;
        limit_ch.valid    <= 1'b0;
        limit_ch.data     <= '0;
        mismatch_count    = 0;
        fed_items         = 0;
        verdict_tally     = '{default: 0};
        byte_limit        = LIMIT_AT_RESET;
        clear_decoder();
        src_gaps          = 1'b1;
        sink_stalls       = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows under the reset limit
        foreach (DIRECTED[i])
            push_item(DIRECTED[i].data_byte, DIRECTED[i].has_byte, DIRECTED[i].last,
                      DIRECTED[i].pin, DIRECTED[i].want);
        drain_results();

        write_limit(16'd0);
        run_entries(200, 1'b1, 1'b0);
        drain_results();

        write_limit(16'hFFFF);
        run_entries(400, 1'b1, 1'b1);
        drain_results();

        // no idling in this stretch
        write_limit(16'($urandom_range(1, 40)));
        run_entries(400, 1'b0, 1'b0);
        drain_results();

        write_limit(16'($urandom_range(0, 24)));
        run_entries(400, 1'b1, 1'b1);
        drain_results();

        write_limit(16'd12);
        run_entries(300, 1'b0, 1'b0);
        drain_results();
        repeat (4) @(posedge i_clk);

        $display("fed %0d items: directed rows, random entries under limits 0 to 65535",
                 fed_items);
        $display("verdicts: %0d accepted, %0d bad encoding, %0d too long, %0d blank",
                 verdict_tally[1], verdict_tally[2], verdict_tally[3], verdict_tally[4]);
        if (pending_results.size() != 0)
            $display("%0t: %0d expected result items never arrived", $time,
                     pending_results.size());
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
